FILE: hdl/fer_pkg.sv
package fer_pkg;

  // register file layout and fixed field widths
  localparam int NUM_COEFS     = 5;
  localparam int COEF_BITS     = 16;
  localparam int TAP_CNT_BITS  = 3;
  localparam int HOT_BITS      = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int OWED_BITS     = 3;

  localparam logic [OWED_BITS-1:0] OWED_MAX = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TAP_COUNT  = 3'd0,
    CFG_HOT_SPOT   = 3'd1,
    CFG_COEF_ZERO  = 3'd2,
    CFG_COEF_ONE   = 3'd3,
    CFG_COEF_TWO   = 3'd4,
    CFG_COEF_THREE = 3'd5,
    CFG_COEF_FOUR  = 3'd6
  } cfg_reg_e;

  // status of an item traveling down the sum pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } stage_tag_t;

endpackage

FILE: hdl/fir_filter_edge_replicate_unit.sv
// FIR filter with edge replication over a stream of signed samples. Each sample item
// yields one filtered item, delayed by lag = taps - 1 - hot_spot samples; before the
// first sample of a vector the window holds copies of it, and the item flagged tlast
// flushes the owed outputs with that sample repeated. Ordinary items are taken one per
// clock unless the output stalls; after a tlast item the input is held while the
// window cells step the flush, lag steps (at most MAX_TAPS - 1), one per cycle unless
// the output stalls. Outputs pass the cell product, sum, and rounding and saturation
// registers. Configuration must be written through cfg_we_i / cfg_idx_i / cfg_data_i
// only while the stream is idle; the block does not enforce this. The coefficient for
// each cell comes from the tap count, so a short filter uses the newest window cells.
module fir_filter_edge_replicate_unit import fer_pkg::*; #(
  parameter int MAX_TAPS       = 5,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]         cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,   // sample_in
  input  logic                             s_axis_tlast,   // last_in
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,   // filtered
  output logic                             m_axis_tuser,   // clipped
  output logic                             m_axis_tlast    // last_out
);

  localparam int DataW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int ProdW = SAMPLE_BITS + COEF_BITS;

  logic [TAP_CNT_BITS-1:0]       tap_count_q;
  logic signed [HOT_BITS-1:0]    hot_spot_q;
  logic signed [COEF_BITS-1:0]   coef_q [NUM_COEFS];

  logic [TAP_CNT_BITS-1:0]       taps, hot, lag;
  logic signed [COEF_BITS-1:0]   cell_coef [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] win [MAX_TAPS];
  logic signed [ProdW-1:0]       prod [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] sample_in, shift_val;

  logic                 started_q, started_d;
  logic                 flushing_q, flushing_d;
  logic [OWED_BITS-1:0] owed_q, owed_d, owed_inc;
  logic [OWED_BITS-1:0] flush_s_q, flush_s_d, flush_p_q, flush_p_d;
  logic                 v1_q, last1_q;
  logic                 accept, step, fill, compute, mark_last;
  logic                 en1, take2;
  stage_tag_t           tag1;
  logic [SAMPLE_BITS-1:0] filtered;
  logic                 clipped, last_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_CNT_BITS'(3);
      hot_spot_q  <= -HOT_BITS'(1);
      coef_q[0]   <= COEF_BITS'(4096);
      coef_q[1]   <= COEF_BITS'(8192);
      coef_q[2]   <= COEF_BITS'(4096);
      coef_q[3]   <= '0;
      coef_q[4]   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TAP_COUNT:  tap_count_q <= cfg_data_i[TAP_CNT_BITS-1:0];
        CFG_HOT_SPOT:   hot_spot_q  <= cfg_data_i[HOT_BITS-1:0];
        CFG_COEF_ZERO:  coef_q[0]   <= cfg_data_i[COEF_BITS-1:0];
        CFG_COEF_ONE:   coef_q[1]   <= cfg_data_i[COEF_BITS-1:0];
        CFG_COEF_TWO:   coef_q[2]   <= cfg_data_i[COEF_BITS-1:0];
        CFG_COEF_THREE: coef_q[3]   <= cfg_data_i[COEF_BITS-1:0];
        CFG_COEF_FOUR:  coef_q[4]   <= cfg_data_i[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective tap count, hot spot and lag
  always_comb begin
    if (tap_count_q == '0) begin
      taps = TAP_CNT_BITS'(1);
    end else if (int'(tap_count_q) > MAX_TAPS) begin
      taps = TAP_CNT_BITS'(MAX_TAPS);
    end else begin
      taps = tap_count_q;
    end
    if (hot_spot_q[HOT_BITS-1]) begin
      hot = taps >> 1;
    end else if (hot_spot_q[TAP_CNT_BITS-1:0] >= taps) begin
      hot = taps - TAP_CNT_BITS'(1);
    end else begin
      hot = hot_spot_q[TAP_CNT_BITS-1:0];
    end
    lag = taps - TAP_CNT_BITS'(1) - hot;
  end

  // tap k of a filter with t taps sits on window cell MAX_TAPS - t + k
  always_comb begin
    for (int j = 0; j < MAX_TAPS; j++) begin
      cell_coef[j] = '0;
      for (int k = 0; k < NUM_COEFS; k++) begin
        if (j + int'(taps) == MAX_TAPS + k) cell_coef[j] = coef_q[k];
      end
    end
  end

  assign sample_in     = s_axis_tdata[SAMPLE_BITS-1:0];
  assign en1           = !v1_q || take2;
  assign s_axis_tready = en1 && !flushing_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign step          = accept || (flushing_q && en1);
  assign fill          = accept && !started_q;
  // the flush repeats the newest sample already in the window
  assign shift_val     = flushing_q ? win[MAX_TAPS-1] : sample_in;
  assign owed_inc      = (owed_q == OWED_MAX) ? OWED_MAX : owed_q + OWED_BITS'(1);

  always_comb begin
    started_d  = started_q;
    flushing_d = flushing_q;
    owed_d     = owed_q;
    flush_s_d  = flush_s_q;
    flush_p_d  = flush_p_q;
    compute    = 1'b0;
    mark_last  = 1'b0;
    if (accept) begin
      started_d = 1'b1;
      if (!s_axis_tlast) begin
        if (owed_inc > lag) begin
          compute = 1'b1;
          owed_d  = owed_inc - OWED_BITS'(1);
        end else begin
          owed_d = owed_inc;
        end
      end else begin
        compute   = ({1'b0, owed_inc} >= {1'b0, lag} + 4'd1);
        mark_last = (lag == '0);
        if (lag == '0) begin
          owed_d    = '0;
          started_d = 1'b0;
        end else begin
          flushing_d = 1'b1;
          flush_s_d  = OWED_BITS'(1);
          flush_p_d  = owed_inc;
        end
      end
    end else if (flushing_q && en1) begin
      compute   = ({1'b0, flush_s_q} + {1'b0, flush_p_q} >= {1'b0, lag} + 4'd1);
      mark_last = (flush_s_q == lag);
      if (flush_s_q == lag) begin
        flushing_d = 1'b0;
        owed_d     = '0;
        started_d  = 1'b0;
      end else begin
        flush_s_d = flush_s_q + OWED_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      flushing_q <= 1'b0;
      owed_q     <= '0;
      flush_s_q  <= '0;
      flush_p_q  <= '0;
      v1_q       <= 1'b0;
      last1_q    <= 1'b0;
    end else begin
      started_q  <= started_d;
      flushing_q <= flushing_d;
      owed_q     <= owed_d;
      flush_s_q  <= flush_s_d;
      flush_p_q  <= flush_p_d;
      if (en1) begin
        v1_q    <= step && compute;
        last1_q <= mark_last;
      end
    end
  end

  genvar j;
  generate
    for (j = 0; j < MAX_TAPS; j++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] neighbor;
      if (j == MAX_TAPS - 1) begin : g_head
        assign neighbor = shift_val;
      end else begin : g_body
        assign neighbor = win[j+1];
      end
      fer_tap_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .step_i        (step),
        .fill_i        (fill),
        .fill_sample_i (sample_in),
        .neighbor_i    (neighbor),
        .coef_i        (cell_coef[j]),
        .sample_o      (win[j]),
        .prod_o        (prod[j])
      );
    end
  endgenerate

  assign tag1.valid = v1_q;
  assign tag1.last  = last1_q;

  fer_out_stage #(
    .MAX_TAPS       (MAX_TAPS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .prod_i     (prod),
    .tag_i      (tag1),
    .take_o     (take2),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .filtered_o (filtered),
    .clipped_o  (clipped),
    .last_o     (last_out)
  );

  assign m_axis_tdata = DataW'(filtered);
  assign m_axis_tuser = clipped;
  assign m_axis_tlast = last_out;

`ifndef NO_ASSERTIONS
  a_flush_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flushing_q |-> !s_axis_tready)
    else $error("input taken during flush");

  a_flush_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flushing_q |-> (flush_s_q <= lag) && (flush_s_q != '0))
    else $error("flush step count out of range");

  a_flush_end_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flushing_q && en1 && (flush_s_q == lag)) |=> v1_q && last1_q && !started_q)
    else $error("final flush step did not issue a last item");

  a_last_no_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast && (lag == '0)) |=> !flushing_q && !started_q && v1_q)
    else $error("zero lag vector end mishandled");
`endif

endmodule

FILE: hdl/fer_tap_cell.sv
module fer_tap_cell import fer_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    step_i,
  input  logic                                    fill_i,
  input  logic signed [SAMPLE_BITS-1:0]           fill_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]           neighbor_i,
  input  logic signed [COEF_BITS-1:0]             coef_i,
  output logic signed [SAMPLE_BITS-1:0]           sample_o,
  output logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod_o
);

  localparam int ProdW = SAMPLE_BITS + COEF_BITS;

  logic signed [SAMPLE_BITS-1:0] sample_d, sample_q;
  logic signed [ProdW-1:0]       prod_d, prod_q;

  always_comb begin
    sample_d = fill_i ? fill_sample_i : neighbor_i;
    prod_d   = sample_d * coef_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (step_i) begin
      sample_q <= sample_d;
    end
  end

  // product follows the window as it will stand after this step
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      prod_q <= prod_d;
    end
  end

  assign sample_o = sample_q;
  assign prod_o   = prod_q;

endmodule

FILE: hdl/fer_out_stage.sv
module fer_out_stage import fer_pkg::*; #(
  parameter int MAX_TAPS       = 5,
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod_i [MAX_TAPS],
  input  stage_tag_t                              tag_i,
  output logic                                    take_o,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output logic [SAMPLE_BITS-1:0]                  filtered_o,
  output logic                                    clipped_o,
  output logic                                    last_o
);

  localparam int ProdW    = SAMPLE_BITS + COEF_BITS;
  localparam int SumW     = ProdW + $clog2(MAX_TAPS);
  localparam int RndW     = ((SumW > COEF_FRAC_BITS) ? SumW : COEF_FRAC_BITS) + 2;
  localparam int RoundPos = (COEF_FRAC_BITS > 0) ? COEF_FRAC_BITS - 1 : 0;
  localparam logic signed [RndW-1:0] RoundHalf =
    (COEF_FRAC_BITS > 0) ? (RndW'(1) << RoundPos) : '0;

  logic signed [SumW-1:0]   sum_d, sum_q;
  logic                     v2_q, last2_q;
  logic                     v3_q, last3_q, clipped_q;
  logic [SAMPLE_BITS-1:0]   filtered_q;
  logic signed [RndW-1:0]   rounded, shifted;
  logic [SAMPLE_BITS-1:0]   sat_val;
  logic                     sat_hit;
  logic                     en2, en3;

  assign en3    = !v3_q || ready_i;
  assign en2    = !v2_q || en3;
  assign take_o = en2;

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      sum_d = sum_d + SumW'(prod_i[k]);
    end
  end

  // round half up, then saturate to the sample range
  always_comb begin
    rounded = RndW'(sum_q) + RoundHalf;
    shifted = rounded >>> COEF_FRAC_BITS;
    sat_hit = !((&shifted[RndW-1:SAMPLE_BITS-1]) || !(|shifted[RndW-1:SAMPLE_BITS-1]));
    if (!sat_hit) begin
      sat_val = shifted[SAMPLE_BITS-1:0];
    end else if (shifted[RndW-1]) begin
      sat_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en2) v2_q <= tag_i.valid;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sum_q   <= sum_d;
      last2_q <= tag_i.last;
    end
    if (en3) begin
      filtered_q <= sat_val;
      clipped_q  <= sat_hit;
      last3_q    <= last2_q;
    end
  end

  assign valid_o    = v3_q;
  assign filtered_o = filtered_q;
  assign clipped_o  = clipped_q;
  assign last_o     = last3_q;

endmodule
